// ===== src/werc_pkg.sv =====
package werc_pkg;

	// Ring depths.
	localparam int MAX_WINDOW   = 4096;
	localparam int MAX_LOOKBACK = 1024;
	localparam int MEAN_DEPTH   = MAX_WINDOW + MAX_LOOKBACK;
	localparam int BAR_AW       = $clog2(MAX_WINDOW);
	localparam int MEAN_AW      = $clog2(MEAN_DEPTH);

	// Shared divider widths.
	localparam int DIV_W  = 65;
	localparam int DVSR_W = 64;
	localparam int CNT_W  = $clog2(DIV_W + 1);

	// Configuration register indexes.
	localparam logic [2:0] REG_WINDOW_LENGTH  = 3'd0;
	localparam logic [2:0] REG_PRICE_MODE     = 3'd1;
	localparam logic [2:0] REG_MIN_TICKS      = 3'd2;
	localparam logic [2:0] REG_TICK_SIZE      = 3'd3;
	localparam logic [2:0] REG_SLOPE_LOOKBACK = 3'd4;
	localparam logic [2:0] REG_TRAP_THRESHOLD = 3'd5;

	// Trapped-bar codes.
	localparam logic [1:0] TRAP_NONE   = 2'd0;
	localparam logic [1:0] TRAP_SHORTS = 2'd1;
	localparam logic [1:0] TRAP_LONGS  = 2'd2;

	// Score constants, Q8.8.
	localparam logic [14:0] SCORE_HALF  = 15'd12800;
	localparam logic [15:0] SCORE_FULL  = 16'd25600;
	localparam logic [15:0] SLOPE_SPAN  = 16'd51200;
	localparam logic [13:0] AUTO_BARS   = 14'd10;
	localparam logic [11:0] AUTO_RANGES = 12'd4;

	typedef struct packed {
		logic [31:0] bar_high;
		logic [31:0] bar_low;
		logic [31:0] bar_close;
		logic [31:0] ask_volume;
		logic [31:0] bid_volume;
	} bar_t;

	typedef struct packed {
		logic [14:0]        absorption_score;
		logic [14:0]        efficiency_score;
		logic signed [15:0] slope_score;
		logic               slope_rising;
		logic [1:0]         trapped_code;
		logic               warmed_up;
	} result_t;

	typedef struct packed {
		logic [31:0]        high;
		logic [31:0]        low;
		logic [31:0]        close;
		logic signed [32:0] delta;
	} bar_word_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [DVSR_W-1:0] divisor;
		logic [CNT_W-1:0]  nbits;
	} div_req_t;

endpackage

// ===== src/werc_ram.sv =====
module werc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== src/werc_div.sv =====
module werc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  werc_pkg::div_req_t            req,
	output logic                          done,
	output logic [werc_pkg::DIV_W-1:0]    quotient,
	output logic [werc_pkg::DVSR_W-1:0]   remainder
);
	import werc_pkg::*;

	logic [DIV_W-1:0]  quo_q;
	logic [DVSR_W-1:0] rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [DVSR_W:0]   trial;
	logic [DVSR_W:0]   diff;
	logic              fits;

	// Restoring division, one quotient bit per cycle. The dividend is
	// left-aligned so that only nbits steps are spent.
	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, req.divisor};
	assign diff  = trial - {1'b0, req.divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= req.nbits;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend << (CNT_W'(DIV_W) - req.nbits);
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[DIV_W-2:0], fits};
			rem_q <= fits ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== src/windowed_effort_result_scorer.sv =====
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    in_data   (bar_t: high, low, close, volumes)
// out       output     out_valid / out_ready  out_data  (result_t: three scores and flags)
// cfg       input      cfg_we                 cfg_index, cfg_data (write only)
//
// Each window bar is read (ST_WREAD, ST_WDATA) and then takes three divisions of 48, 64
// and 48 quotient bits; the slope pass reads each window bar (ST_SREAD, ST_SDATA), and the
// three means and three scores follow once per bar. The run time is set by the single
// bit-serial divider. The automatic mode decision is made once.
// A bar still in warmup skips the window and the divisions and goes to ST_FINISH.
// Reset clears pointers, bar count and the automatic mode latch; ring contents are not
// cleared and are only read where they have been written.
// A finished result waits in the output register while the next bar is taken in; the
// block stalls at the end of that bar until the output register is free.
module windowed_effort_result_scorer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  werc_pkg::bar_t     in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output werc_pkg::result_t  out_data,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import werc_pkg::*;

	// Sequencer states.
	localparam logic [4:0] ST_IDLE    = 5'd0;
	localparam logic [4:0] ST_AUTO    = 5'd1;
	localparam logic [4:0] ST_DECIDE  = 5'd2;
	localparam logic [4:0] ST_WREAD   = 5'd3;
	localparam logic [4:0] ST_WDATA   = 5'd4;
	localparam logic [4:0] ST_DIV_TQ  = 5'd5;
	localparam logic [4:0] ST_DIV_AR  = 5'd6;
	localparam logic [4:0] ST_DIV_ER  = 5'd7;
	localparam logic [4:0] ST_MEAN_A  = 5'd8;
	localparam logic [4:0] ST_MEAN_E  = 5'd9;
	localparam logic [4:0] ST_MEAN_D  = 5'd10;
	localparam logic [4:0] ST_PREP_A  = 5'd11;
	localparam logic [4:0] ST_GO_A    = 5'd12;
	localparam logic [4:0] ST_SCORE_A = 5'd13;
	localparam logic [4:0] ST_PREP_E  = 5'd14;
	localparam logic [4:0] ST_GO_E    = 5'd15;
	localparam logic [4:0] ST_SCORE_E = 5'd16;
	localparam logic [4:0] ST_SREAD   = 5'd17;
	localparam logic [4:0] ST_SDATA   = 5'd18;
	localparam logic [4:0] ST_PREP_S  = 5'd19;
	localparam logic [4:0] ST_GO_S    = 5'd20;
	localparam logic [4:0] ST_SCORE_S = 5'd21;
	localparam logic [4:0] ST_FINISH  = 5'd22;

	localparam int BW = $bits(bar_word_t);

	logic [4:0] state_q;

	// Configuration registers.
	logic [11:0] wlen_q;
	logic [1:0]  pmode_q;
	logic [9:0]  mint_q;
	logic [31:0] tick_q;
	logic [10:0] lb_q;
	logic [23:0] trap_q;

	// Block state.
	logic [BAR_AW-1:0]  bar_ptr_q;
	logic [MEAN_AW-1:0] mean_ptr_q;
	logic [13:0]        bars_q;
	logic               mode_fixed_q;
	logic               fixed_mode_q;

	// Per-bar working registers.
	bar_t               in_q;
	logic [11:0]        k_q;
	logic               same_q;
	logic               pv_s1;
	logic               last_s1;
	logic               mode_q;
	logic [31:0]        close_p_q;
	logic [31:0]        ad_q;
	logic [47:0]        tq_q;
	logic [47:0]        ar_q;
	logic [59:0]        sum_abs_q;
	logic [59:0]        sum_eff_q;
	logic [43:0]        sum_ad_q;
	logic [47:0]        min_a_q, max_a_q, min_e_q, max_e_q;
	logic [47:0]        mean_a_q, mean_e_q;
	logic [31:0]        avg_ad_q;
	logic [55:0]        thr_q;
	logic [DIV_W-1:0]   prod_q;
	logic signed [48:0] raw_q, mn_q, mx_q;
	result_t            res_q;
	logic               out_valid_q;
	result_t            out_q;

	// Divider request: the start pulse comes from the sequencer, the operands from the
	// datapath.
	logic               div_start_q;
	logic               div_start_n;
	logic [DIV_W-1:0]   div_dvd_q;
	logic [DVSR_W-1:0]  div_dvs_q;
	logic [CNT_W-1:0]   div_nbits_q;
	div_req_t           div_req;

	// Clamped configuration.
	logic [11:0] w_eff;
	logic [10:0] l_eff;
	logic [11:0] l_plus;
	logic [11:0] min_bars;
	logic [31:0] tick_eff;
	logic [25:0] floor_t;
	logic        warm_n;
	logic        slope_ok;
	logic        incl;
	logic        last_k;

	assign w_eff    = (wlen_q < 12'd2) ? 12'd2 : wlen_q;
	assign l_eff    = (lb_q == '0) ? 11'd1
	                : (lb_q > 11'(MAX_LOOKBACK)) ? 11'(MAX_LOOKBACK) : lb_q;
	assign l_plus   = {1'b0, l_eff} + 12'd1;
	assign min_bars = (w_eff > l_plus) ? w_eff : l_plus;
	assign tick_eff = (tick_q == '0) ? 32'd1 : tick_q;
	assign floor_t  = {((mint_q == '0) ? 10'd1 : mint_q), 16'd0};
	assign last_k   = (k_q == w_eff - 12'd1);

	// Warmup: not enough bars for the window and the lookback, or automatic mode before its decision bar.
	assign warm_n = (bars_q < {2'b00, min_bars}) || (pmode_q[1] && bars_q < AUTO_BARS);

	// Slope is defined once the lookback reaches back past the warmup bars; a window
	// bar joins the slope extremes under the same test shifted by its age.
	assign slope_ok = ($signed({2'b00, bars_q}) - $signed({5'b0, l_eff}))
	                  >= $signed({4'b0, min_bars});
	assign incl     = ($signed({2'b00, bars_q}) - $signed({4'b0, k_q})
	                  - $signed({5'b0, l_eff})) >= $signed({4'b0, min_bars});

	function automatic logic [BAR_AW-1:0] bar_at(input logic [BAR_AW-1:0] ptr,
	                                             input logic [BAR_AW-1:0] back);
		bar_at = ptr - back;
	endfunction

	function automatic logic [MEAN_AW-1:0] mean_at(input logic [MEAN_AW-1:0] ptr,
	                                               input logic [MEAN_AW-1:0] back);
		logic [MEAN_AW:0] d;
		d = {1'b0, ptr} - {1'b0, back};
		if (d[MEAN_AW]) begin
			d = d + (MEAN_AW+1)'(MEAN_DEPTH);
		end
		mean_at = d[MEAN_AW-1:0];
	endfunction

	// Bar ring: one word per bar holds high, low, close and delta. Port A reads the
	// window bar, port B the bar before it.
	logic        in_fire;
	bar_word_t   bar_wr;
	bar_word_t   bar_a, bar_b;
	logic [BW-1:0] bar_a_raw, bar_b_raw;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;

	assign bar_wr.high  = in_data.bar_high;
	assign bar_wr.low   = in_data.bar_low;
	assign bar_wr.close = in_data.bar_close;
	assign bar_wr.delta = $signed({1'b0, in_data.ask_volume}) - $signed({1'b0, in_data.bid_volume});
	assign bar_a = bar_word_t'(bar_a_raw);
	assign bar_b = bar_word_t'(bar_b_raw);

	werc_ram #(.WIDTH(BW), .DEPTH(MAX_WINDOW)) u_bar_ram (
		.clk     (clk),
		.we      (in_fire),
		.waddr   (bar_ptr_q),
		.wdata   (BW'(bar_wr)),
		.raddr_a (bar_at(bar_ptr_q, k_q)),
		.raddr_b (bar_at(bar_ptr_q, k_q + 12'd1)),
		.rdata_a (bar_a_raw),
		.rdata_b (bar_b_raw)
	);

	// Ring of past window absorption means. A warmup bar records zero.
	logic        mean_we;
	logic [47:0] mean_a_rd, mean_b_rd;
	logic        div_done;
	logic [DIV_W-1:0]  div_quo;
	logic [DVSR_W-1:0] div_rem;

	assign mean_we = ((state_q == ST_DECIDE) && warm_n) || ((state_q == ST_MEAN_D) && div_done);

	werc_ram #(.WIDTH(48), .DEPTH(MEAN_DEPTH)) u_mean_ram (
		.clk     (clk),
		.we      (mean_we),
		.waddr   (mean_ptr_q),
		.wdata   ((state_q == ST_DECIDE) ? 48'd0 : mean_a_q),
		.raddr_a (mean_at(mean_ptr_q, {1'b0, k_q})),
		.raddr_b (mean_at(mean_ptr_q, MEAN_AW'(k_q) + MEAN_AW'(l_eff))),
		.rdata_a (mean_a_rd),
		.rdata_b (mean_b_rd)
	);

	// One divider serves the tick count, both ratios, the three means and the
	// three scores.
	assign div_req = {div_start_q, div_dvd_q, div_dvs_q, div_nbits_q};

	werc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (div_req),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// A division is started on entry to each divider state: right after the window
	// bar is read, when the previous division of the chain is done, and before each
	// score unless its extremes are equal.
	always_comb begin
		div_start_n = 1'b0;
		unique case (state_q) inside
			ST_WDATA: div_start_n = 1'b1;
			ST_DIV_TQ, ST_DIV_AR, ST_MEAN_A, ST_MEAN_E: div_start_n = div_done;
			ST_DIV_ER: div_start_n = div_done && last_k;
			ST_GO_A: div_start_n = (max_a_q != min_a_q);
			ST_GO_E: div_start_n = (max_e_q != min_e_q);
			ST_GO_S: div_start_n = (mx_q > mn_q);
			default: div_start_n = 1'b0;
		endcase
	end

	// Round half up: the quotient moves up when twice the remainder reaches the divisor.
	logic rnd;
	assign rnd = {div_rem, 1'b0} >= {1'b0, div_dvs_q};

	// Window element terms.
	logic signed [32:0] range_a;
	logic [31:0]        pc;
	logic [31:0]        ad_a;
	logic signed [32:0] range_in;
	logic [47:0]        tq_n;
	logic [47:0]        er_n;
	logic               k0;
	logic [59:0]        sum_abs_n, sum_eff_n;
	logic [43:0]        sum_ad_n;
	logic signed [32:0] d_cur;
	logic [31:0]        ad_cur;
	logic [1:0]         trap_n;
	logic signed [48:0] s_n;
	logic [14:0]        score_n;
	logic signed [16:0] slope_n;

	assign k0       = (k_q == '0);
	assign range_a  = $signed({1'b0, bar_a.high}) - $signed({1'b0, bar_a.low});
	assign range_in = $signed({1'b0, in_q.bar_high}) - $signed({1'b0, in_q.bar_low});
	assign pc       = !mode_q ? (range_a[32] ? 32'd0 : range_a[31:0])
	                : (bar_a.close >= bar_b.close) ? bar_a.close - bar_b.close
	                : bar_b.close - bar_a.close;
	assign ad_a     = bar_a.delta[32] ? 32'(-bar_a.delta) : bar_a.delta[31:0];
	assign tq_n     = (div_quo[47:0] < 48'(floor_t)) ? 48'(floor_t) : div_quo[47:0];
	assign er_n     = div_quo[47:0];
	assign sum_abs_n = (k0 ? 60'd0 : sum_abs_q) + 60'(ar_q);
	assign sum_eff_n = (k0 ? 60'd0 : sum_eff_q) + 60'(er_n);
	assign sum_ad_n  = (k0 ? 44'd0 : sum_ad_q) + 44'(ad_q);
	assign d_cur     = $signed({1'b0, in_q.ask_volume}) - $signed({1'b0, in_q.bid_volume});
	assign ad_cur    = d_cur[32] ? 32'(-d_cur) : d_cur[31:0];
	assign s_n       = $signed({1'b0, mean_a_rd}) - $signed({1'b0, mean_b_rd});
	assign score_n   = div_quo[14:0] + 15'(rnd);
	assign slope_n   = $signed({1'b0, div_quo[15:0]}) + $signed(17'(rnd))
	                 - $signed({1'b0, SCORE_FULL});

	// Trapped test on the current bar against the previous close: a falling close with
	// buying pressure traps longs, a rising close with selling pressure traps shorts.
	assign trap_n = (in_q.bar_close < close_p_q && !d_cur[32] && d_cur != '0
	                 && 56'({ad_cur, 16'd0}) > thr_q) ? TRAP_LONGS
	              : (in_q.bar_close > close_p_q && d_cur[32]
	                 && 56'({ad_cur, 16'd0}) > thr_q) ? TRAP_SHORTS : TRAP_NONE;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q  <= 12'd15;
			pmode_q <= 2'd1;
			mint_q  <= 10'd1;
			tick_q  <= 32'd2500;
			lb_q    <= 11'd4;
			trap_q  <= 24'd19661;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW_LENGTH:  wlen_q  <= cfg_data[11:0];
				REG_PRICE_MODE:     pmode_q <= cfg_data[1:0];
				REG_MIN_TICKS:      mint_q  <= cfg_data[9:0];
				REG_TICK_SIZE:      tick_q  <= cfg_data;
				REG_SLOPE_LOOKBACK: lb_q    <= cfg_data[10:0];
				REG_TRAP_THRESHOLD: trap_q  <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// Control: sequencer, pointers, bar count, mode latch and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			bar_ptr_q    <= '0;
			mean_ptr_q   <= '0;
			bars_q       <= '0;
			mode_fixed_q <= 1'b0;
			fixed_mode_q <= 1'b1;
			out_valid_q  <= 1'b0;
			div_start_q  <= 1'b0;
			pv_s1        <= 1'b0;
		end else begin
			div_start_q <= div_start_n;
			pv_s1 <= (state_q == ST_AUTO) && (k_q <= AUTO_RANGES);
			// A new result is loaded once the register is free; otherwise a transfer
			// out empties it.
			if (state_q == ST_FINISH && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (pmode_q[1] && !mode_fixed_q && bars_q >= AUTO_BARS) begin
							state_q <= ST_AUTO;
						end else begin
							state_q <= ST_DECIDE;
						end
					end
				end
				ST_AUTO: begin
					// The automatic choice looks at the four bars before this one and
					// compares their signed ranges with the current range.
					if (pv_s1 && last_s1) begin
						fixed_mode_q <= same_q && (range_a == range_in);
						mode_fixed_q <= 1'b1;
						state_q      <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					state_q <= warm_n ? ST_FINISH : ST_WREAD;
				end
				ST_WREAD: state_q <= ST_WDATA;
				ST_WDATA: state_q <= ST_DIV_TQ;
				ST_DIV_TQ: begin
					if (div_done) begin
						state_q <= ST_DIV_AR;
					end
				end
				ST_DIV_AR: begin
					if (div_done) begin
						state_q <= ST_DIV_ER;
					end
				end
				ST_DIV_ER: begin
					if (div_done) begin
						state_q <= last_k ? ST_MEAN_A : ST_WREAD;
					end
				end
				ST_MEAN_A: begin
					if (div_done) begin
						state_q <= ST_MEAN_E;
					end
				end
				ST_MEAN_E: begin
					if (div_done) begin
						state_q <= ST_MEAN_D;
					end
				end
				ST_MEAN_D: begin
					if (div_done) begin
						state_q <= ST_PREP_A;
					end
				end
				ST_PREP_A: state_q <= ST_GO_A;
				ST_GO_A: begin
					state_q <= (max_a_q == min_a_q) ? ST_PREP_E : ST_SCORE_A;
				end
				ST_SCORE_A: begin
					if (div_done) begin
						state_q <= ST_PREP_E;
					end
				end
				ST_PREP_E: state_q <= ST_GO_E;
				ST_GO_E: begin
					if (max_e_q == min_e_q) begin
						state_q <= slope_ok ? ST_SREAD : ST_FINISH;
					end else begin
						state_q <= ST_SCORE_E;
					end
				end
				ST_SCORE_E: begin
					if (div_done) begin
						state_q <= slope_ok ? ST_SREAD : ST_FINISH;
					end
				end
				ST_SREAD: state_q <= ST_SDATA;
				ST_SDATA: state_q <= last_k ? ST_PREP_S : ST_SREAD;
				ST_PREP_S: state_q <= ST_GO_S;
				ST_GO_S: begin
					state_q <= (mx_q > mn_q) ? ST_SCORE_S : ST_FINISH;
				end
				ST_SCORE_S: begin
					if (div_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					// Hand the result over once the output register is free, then move
					// both rings on by one bar.
					if (!out_valid_q || out_ready) begin
						bar_ptr_q   <= bar_ptr_q + BAR_AW'(1);
						mean_ptr_q  <= (mean_ptr_q == MEAN_AW'(MEAN_DEPTH - 1)) ? '0
						             : mean_ptr_q + MEAN_AW'(1);
						if (bars_q != '1) begin
							bars_q <= bars_q + 14'd1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		last_s1 <= (k_q == AUTO_RANGES);
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					in_q   <= in_data;
					k_q    <= 12'd1;
					same_q <= 1'b1;
				end
			end
			ST_AUTO: begin
				if (k_q <= AUTO_RANGES) begin
					k_q <= k_q + 12'd1;
				end
				if (pv_s1 && range_a != range_in) begin
					same_q <= 1'b0;
				end
			end
			ST_DECIDE: begin
				mode_q <= pmode_q[1] ? (mode_fixed_q ? fixed_mode_q : 1'b1) : pmode_q[0];
				k_q    <= '0;
				// All fields start at zero; only the warmup flag depends on the bar.
				res_q  <= result_t'({49'd0, !warm_n});
			end
			ST_WDATA: begin
				ad_q <= ad_a;
				if (k0) begin
					close_p_q <= bar_b.close;
				end
				div_dvd_q   <= DIV_W'({pc, 16'd0});
				div_dvs_q   <= DVSR_W'(tick_eff);
				div_nbits_q <= CNT_W'(48);
			end
			ST_DIV_TQ: begin
				if (div_done) begin
					tq_q <= tq_n;
					div_dvd_q   <= DIV_W'({ad_q, 32'd0});
					div_dvs_q   <= DVSR_W'(tq_n);
					div_nbits_q <= CNT_W'(64);
				end
			end
			ST_DIV_AR: begin
				if (div_done) begin
					ar_q <= div_quo[47:0];
					div_dvd_q   <= DIV_W'(tq_q);
					div_dvs_q   <= DVSR_W'((ad_q == '0) ? 32'd1 : ad_q);
					div_nbits_q <= CNT_W'(48);
				end
			end
			ST_DIV_ER: begin
				if (div_done) begin
					sum_abs_q <= sum_abs_n;
					sum_eff_q <= sum_eff_n;
					sum_ad_q  <= sum_ad_n;
					if (k0 || ar_q < min_a_q) min_a_q <= ar_q;
					if (k0 || ar_q > max_a_q) max_a_q <= ar_q;
					if (k0 || er_n < min_e_q) min_e_q <= er_n;
					if (k0 || er_n > max_e_q) max_e_q <= er_n;
					k_q <= k_q + 12'd1;
					div_dvd_q   <= DIV_W'(sum_abs_n);
					div_dvs_q   <= DVSR_W'(w_eff);
					div_nbits_q <= CNT_W'(60);
				end
			end
			ST_MEAN_A: begin
				if (div_done) begin
					mean_a_q <= div_quo[47:0];
					div_dvd_q <= DIV_W'(sum_eff_q);
				end
			end
			ST_MEAN_E: begin
				if (div_done) begin
					mean_e_q <= div_quo[47:0];
					div_dvd_q   <= DIV_W'(sum_ad_q);
					div_nbits_q <= CNT_W'(44);
				end
			end
			ST_MEAN_D: begin
				if (div_done) begin
					avg_ad_q <= div_quo[31:0];
				end
			end
			ST_PREP_A: begin
				thr_q  <= 56'(trap_q) * 56'(avg_ad_q);
				prod_q <= DIV_W'(mean_a_q - min_a_q) * DIV_W'(SCORE_FULL);
			end
			ST_GO_A: begin
				res_q.trapped_code <= trap_n;
				if (max_a_q == min_a_q) begin
					res_q.absorption_score <= SCORE_HALF;
				end
				div_dvd_q   <= prod_q;
				div_dvs_q   <= DVSR_W'(max_a_q - min_a_q);
				div_nbits_q <= CNT_W'(DIV_W);
			end
			ST_SCORE_A: begin
				if (div_done) begin
					res_q.absorption_score <= score_n;
				end
			end
			ST_PREP_E: begin
				prod_q <= DIV_W'(mean_e_q - min_e_q) * DIV_W'(SCORE_FULL);
			end
			ST_GO_E: begin
				k_q <= '0;
				if (max_e_q == min_e_q) begin
					res_q.efficiency_score <= SCORE_HALF;
				end
				div_dvd_q <= prod_q;
				div_dvs_q <= DVSR_W'(max_e_q - min_e_q);
			end
			ST_SCORE_E: begin
				if (div_done) begin
					res_q.efficiency_score <= score_n;
				end
			end
			ST_SDATA: begin
				if (k0) begin
					raw_q <= s_n;
					mn_q  <= s_n;
					mx_q  <= s_n;
				end else if (incl) begin
					if (s_n < mn_q) mn_q <= s_n;
					if (s_n > mx_q) mx_q <= s_n;
				end
				k_q <= k_q + 12'd1;
			end
			ST_PREP_S: begin
				res_q.slope_rising <= !raw_q[48];
				prod_q <= DIV_W'(49'(raw_q - mn_q)) * DIV_W'(SLOPE_SPAN);
			end
			ST_GO_S: begin
				div_dvd_q <= prod_q;
				div_dvs_q <= DVSR_W'(49'(mx_q - mn_q));
			end
			ST_SCORE_S: begin
				if (div_done) begin
					res_q.slope_score <= slope_n[15:0];
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					out_q <= res_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== src/werc_chk.sv =====
module werc_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input werc_pkg::result_t out_data
);
	import werc_pkg::*;

	// A result that is not taken stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");

	// Bars are worked one at a time: a transfer in closes the input for the next cycle.
	a_one_bar: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a bar is in work");

	// During warmup every field is zero.
	a_warm_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.warmed_up |->
		out_data.absorption_score == '0 && out_data.efficiency_score == '0 &&
		out_data.slope_score == '0 && !out_data.slope_rising &&
		out_data.trapped_code == TRAP_NONE)
		else $error("nonzero result during warmup");

	// Scores stay within their scale.
	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
		out_data.absorption_score <= 15'(SCORE_FULL) &&
		out_data.efficiency_score <= 15'(SCORE_FULL) &&
		out_data.slope_score <= $signed(SCORE_FULL) &&
		out_data.slope_score >= -$signed(SCORE_FULL) &&
		out_data.trapped_code != 2'd3)
		else $error("score out of range");

endmodule

bind windowed_effort_result_scorer werc_chk u_werc_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
